[design/cubic_hermite_3d_evaluator_unit_macros.svh]
// Assertion macros shared by the checker of the cubic Hermite evaluator.
`ifndef CUBIC_HERMITE_3D_EVALUATOR_UNIT_MACROS_SVH
`define CUBIC_HERMITE_3D_EVALUATOR_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is active.
`define CHEV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("chev assertion failed");

// Clocked assertion that is also checked while reset is active.
`define CHEV_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("chev assertion failed");

`endif

[design/chev_pkg.sv]
// Types, codes and constants shared by the cubic Hermite evaluator modules.
`default_nettype none

package chev_pkg;

  localparam int unsigned MAX_KNOTS_DEF = 64;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned COEF_W = 34;

  localparam logic [2:0] REQ_APPEND = 3'd0;
  localparam logic [2:0] REQ_POS    = 3'd1;
  localparam logic [2:0] REQ_VEL    = 3'd2;
  localparam logic [2:0] REQ_ACC    = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOT_INC = 2'd3;

  localparam logic signed [COEF_W-1:0] Q30 = 34'sh0_4000_0000;
  localparam logic signed [COEF_W-1:0] Q31 = 34'sh0_8000_0000;

  typedef enum logic [1:0] {
    OP_POS,
    OP_VEL,
    OP_ACC
  } op_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [31:0]        at_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        at_time;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } knot_t;

  // Basis weights of one query, shared by all lanes.
  typedef struct packed {
    logic signed [COEF_W-1:0] c0;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] c3;
  } coef_t;

endpackage

`default_nettype wire

[design/chev_div.sv]
// Iterative signed 64-bit by unsigned 32-bit divider, one quotient bit a cycle.
`default_nettype none

module chev_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] dividend_i,
  input  logic [31:0]        divisor_i,
  output logic               done_o,
  output logic signed [63:0] quot_o
);

  localparam int unsigned STEPS = 64;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic             neg_q;
  logic [63:0]      mag_q;
  logic [31:0]      rem_q;
  logic [32:0]      rem_sh;
  logic             fits;

  assign rem_sh = {rem_q, mag_q[63]};
  assign fits   = rem_sh >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      done_q <= (cnt_q == CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // The remainder stays below the divisor, so 32 bits hold it.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[63];
      mag_q <= dividend_i[63] ? 64'(-dividend_i) : 64'(dividend_i);
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      mag_q <= {mag_q[62:0], fits};
      rem_q <= fits ? 32'(rem_sh - {1'b0, divisor_i}) : rem_sh[31:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? signed'(-mag_q) : signed'(mag_q);

endmodule

`default_nettype wire

[design/chev_lane.sv]
// One lane: evaluates the Hermite expression for one coordinate term by term.
`default_nettype none

module chev_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  chev_pkg::op_e      op_i,
  input  chev_pkg::coef_t    coef_i,
  input  logic [31:0]        dt_i,
  input  logic signed [31:0] pa_i,
  input  logic signed [31:0] pb_i,
  input  logic signed [31:0] va_i,
  input  logic signed [31:0] vb_i,
  output logic               done_o,
  output logic signed [31:0] res_o
);

  typedef enum logic [7:0] {
    L_IDLE  = 8'b0000_0001,
    L_MUL   = 8'b0000_0010,
    L_DIV   = 8'b0000_0100,
    L_DWAIT = 8'b0000_1000,
    L_ASR   = 8'b0001_0000,
    L_MDT   = 8'b0010_0000,
    L_ACC   = 8'b0100_0000,
    L_DONE  = 8'b1000_0000
  } lstate_e;

  typedef enum logic [1:0] {
    SC_ONE,
    SC_TWO,
    SC_SIX
  } scale_e;

  localparam int unsigned CW = chev_pkg::COEF_W;
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  lstate_e            state_q, state_d;
  logic [1:0]         term_q, term_d;
  logic [1:0]         nd_q, nd_d;
  logic signed [63:0] val_q, val_d;
  logic signed [63:0] acc_q, acc_d;

  logic signed [CW-1:0] dp, x_op, c_op, op_a, op_b;
  logic signed [67:0]   prod;
  logic [1:0]           t_nd, t_last;
  logic                 t_mdt;
  scale_e               t_scale;
  logic signed [63:0]   scaled;
  logic                 div_done;
  logic signed [63:0]   div_quot;

  assign dp = {{2{pb_i[31]}}, pb_i} - {{2{pa_i[31]}}, pa_i};

  // Operand, division count and post-scaling of the current term.
  always_comb begin
    x_op    = '0;
    c_op    = '0;
    t_nd    = 2'd0;
    t_mdt   = 1'b0;
    t_scale = SC_ONE;
    t_last  = 2'd2;
    case (op_i)
      chev_pkg::OP_POS: begin
        t_last = 2'd3;
        case (term_q)
          2'd0: begin
            x_op = {{2{pa_i[31]}}, pa_i};
            c_op = coef_i.c0;
          end
          2'd1: begin
            x_op = {{2{pb_i[31]}}, pb_i};
            c_op = coef_i.c1;
          end
          2'd2: begin
            x_op  = {{2{va_i[31]}}, va_i};
            c_op  = coef_i.c2;
            t_mdt = 1'b1;
          end
          default: begin
            x_op  = {{2{vb_i[31]}}, vb_i};
            c_op  = coef_i.c3;
            t_mdt = 1'b1;
          end
        endcase
      end
      chev_pkg::OP_VEL: begin
        case (term_q)
          2'd0: begin
            x_op = dp;
            c_op = coef_i.c0;
            t_nd = 2'd1;
          end
          2'd1: begin
            x_op = {{2{va_i[31]}}, va_i};
            c_op = coef_i.c1;
          end
          default: begin
            x_op = {{2{vb_i[31]}}, vb_i};
            c_op = coef_i.c2;
          end
        endcase
      end
      chev_pkg::OP_ACC: begin
        case (term_q)
          2'd0: begin
            x_op    = dp;
            c_op    = coef_i.c0;
            t_nd    = 2'd2;
            t_scale = SC_SIX;
          end
          2'd1: begin
            x_op    = {{2{va_i[31]}}, va_i};
            c_op    = coef_i.c1;
            t_nd    = 2'd1;
            t_scale = SC_TWO;
          end
          default: begin
            x_op    = {{2{vb_i[31]}}, vb_i};
            c_op    = coef_i.c2;
            t_nd    = 2'd1;
            t_scale = SC_TWO;
          end
        endcase
      end
      default: ;
    endcase
  end

  // The one multiplier serves both the weight product and the scaling by dt.
  assign op_a = (state_q == L_MDT) ? val_q[CW-1:0] : x_op;
  assign op_b = (state_q == L_MDT) ? signed'({2'b00, dt_i}) : c_op;
  assign prod = op_a * op_b;

  always_comb begin
    case (t_scale)
      SC_TWO:  scaled = val_q <<< 1;
      SC_SIX:  scaled = (val_q <<< 2) + (val_q <<< 1);
      default: scaled = val_q;
    endcase
  end

  always_comb begin
    state_d = state_q;
    term_d  = term_q;
    nd_d    = nd_q;
    val_d   = val_q;
    acc_d   = acc_q;
    case (state_q)
      L_IDLE, L_DONE: begin
        if (start_i) begin
          term_d  = 2'd0;
          acc_d   = '0;
          state_d = L_MUL;
        end
      end
      L_MUL: begin
        val_d   = prod[63:0];
        nd_d    = t_nd;
        state_d = (t_nd != 2'd0) ? L_DIV : L_ASR;
      end
      L_DIV: begin
        state_d = L_DWAIT;
      end
      L_DWAIT: begin
        if (div_done) begin
          val_d   = div_quot;
          nd_d    = nd_q - 2'd1;
          state_d = (nd_q == 2'd1) ? L_ASR : L_DIV;
        end
      end
      L_ASR: begin
        val_d   = val_q >>> 30;
        state_d = t_mdt ? L_MDT : L_ACC;
      end
      L_MDT: begin
        val_d   = prod[63:0];
        state_d = L_ACC;
      end
      L_ACC: begin
        acc_d = acc_q + scaled;
        if (term_q == t_last) begin
          state_d = L_DONE;
        end else begin
          term_d  = term_q + 2'd1;
          state_d = L_MUL;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      term_q  <= '0;
      nd_q    <= '0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
      nd_q    <= nd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    acc_q <= acc_d;
  end

  chev_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == L_DIV),
    .dividend_i (val_q),
    .divisor_i  (dt_i),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign done_o = (state_q == L_DONE);

  always_comb begin
    if (acc_q > SAT_HI) begin
      res_o = 32'sh7fff_ffff;
    end else if (acc_q < SAT_LO) begin
      res_o = 32'sh8000_0000;
    end else begin
      res_o = acc_q[31:0];
    end
  end

endmodule

`default_nettype wire

[design/cubic_hermite_3d_evaluator_unit.sv]
// Top level of the cubic Hermite evaluator: knot table, search, fraction and lanes.
//
// Usage: items enter on in_valid_i/in_ready_o as chev_pkg::in_item_t and each
// item yields exactly one result item on out_valid_o/out_ready_i as
// chev_pkg::out_item_t. One item is worked on at a time; in_ready_o is high
// only while the block is idle.
// Appends, clears, unused selectors and rejected queries go straight to the
// output state; a query on a lone knot first reads that knot. A query on
// n knots first scans the knot memory through one read port, then runs the
// 64-step fraction divider and then three lanes (x, y, z) in parallel. Position
// needs no division in the lanes; velocity and acceleration also use the
// 64-step divider in each lane. in_ready_o returns as the result moves into
// the output register, so the next item can be taken from then on.
// Reset empties the table at once (knot count zero); the knot memory itself
// is not cleared. A result that the receiver stalls is held in the output
// register; the next item can be taken meanwhile, and its result waits in
// the result register until the output register is free.
`default_nettype none

module cubic_hermite_3d_evaluator_unit #(
  parameter int unsigned MAX_KNOTS = chev_pkg::MAX_KNOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  chev_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output chev_pkg::out_item_t out_item_o
);

  localparam int unsigned IDX_W = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_KNOTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KNOTS);
  localparam int unsigned CW = chev_pkg::COEF_W;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_SCAN   = 11'b000_0000_0010,
    S_FETCH  = 11'b000_0000_0100,
    S_PAIR   = 11'b000_0000_1000,
    S_FRAC   = 11'b000_0001_0000,
    S_SQ     = 11'b000_0010_0000,
    S_CUBE   = 11'b000_0100_0000,
    S_COEF   = 11'b000_1000_0000,
    S_LSTART = 11'b001_0000_0000,
    S_LANES  = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [31:0]         first_time_q, first_time_d;
  logic [31:0]         last_time_q, last_time_d;
  logic [31:0]         t_q, t_d;
  chev_pkg::op_e       op_q, op_d;
  logic                single_q, single_d;
  logic [IDX_W-1:0]    a_q, a_d;
  logic [IDX_W-1:0]    scan_q, scan_d;
  logic                cmp_v_q, cmp_v_d;
  logic [IDX_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic [31:0]         dt_q, dt_d;
  logic [30:0]         frac_q, frac_d;
  logic [30:0]         frac2_q, frac2_d;
  logic [30:0]         frac3_q, frac3_d;
  chev_pkg::coef_t     coef_q, coef_d;
  chev_pkg::out_item_t res_q, res_d;
  logic                out_valid_q, out_valid_d;
  chev_pkg::out_item_t out_q, out_d;

  chev_pkg::knot_t knot_mem [MAX_KNOTS];
  chev_pkg::knot_t rd_a_q, rd_b_q, wr_knot;
  logic [IDX_W-1:0] addr_a, addr_b;
  logic             mem_we;

  logic               scan_issue;
  logic               frac_start, frac_done;
  logic signed [63:0] frac_dividend, frac_quot;
  logic [31:0]        seg_u;
  logic [30:0]        sq_b;
  logic [61:0]        sq_prod;
  logic               lane_start;

  logic [chev_pkg::NUM_LANES-1:0] lane_done;
  logic signed [31:0] lane_pa  [chev_pkg::NUM_LANES];
  logic signed [31:0] lane_pb  [chev_pkg::NUM_LANES];
  logic signed [31:0] lane_va  [chev_pkg::NUM_LANES];
  logic signed [31:0] lane_vb  [chev_pkg::NUM_LANES];
  logic signed [31:0] lane_res [chev_pkg::NUM_LANES];

  assign wr_knot = '{at_time: in_item_i.at_time,
                     pos_x: in_item_i.pos_x, pos_y: in_item_i.pos_y, pos_z: in_item_i.pos_z,
                     vel_x: in_item_i.vel_x, vel_y: in_item_i.vel_y, vel_z: in_item_i.vel_z};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      knot_mem[cnt_q[IDX_W-1:0]] <= wr_knot;
    end
    rd_a_q <= knot_mem[addr_a];
    rd_b_q <= knot_mem[addr_b];
  end

  assign scan_issue = ((CNT_W + 1)'(scan_q) + (CNT_W + 1)'(2)) <= (CNT_W + 1)'(cnt_q);

  assign seg_u         = t_q - rd_a_q.at_time;
  assign frac_dividend = signed'({2'b00, seg_u, 30'd0});

  assign sq_b    = (state_q == S_SQ) ? frac_q : frac2_q;
  assign sq_prod = frac_q * sq_b;

  // Basis weights from the fraction and its square and cube.
  always_comb begin
    logic signed [CW-1:0] fa, fa2, fa3, dg;
    fa  = signed'({3'b000, frac_q});
    fa2 = signed'({3'b000, frac2_q});
    fa3 = signed'({3'b000, frac3_q});
    dg  = fa - fa2;
    coef_d = '0;
    case (op_q)
      chev_pkg::OP_POS: begin
        coef_d.c0 = (fa3 <<< 1) - (fa2 <<< 1) - fa2 + chev_pkg::Q30;
        coef_d.c1 = (fa2 <<< 1) + fa2 - (fa3 <<< 1);
        coef_d.c2 = fa3 - (fa2 <<< 1) + fa;
        coef_d.c3 = fa3 - fa2;
      end
      chev_pkg::OP_VEL: begin
        coef_d.c0 = (dg <<< 2) + (dg <<< 1);
        coef_d.c1 = (fa2 <<< 1) + fa2 - (fa <<< 2) + chev_pkg::Q30;
        coef_d.c2 = (fa2 <<< 1) + fa2 - (fa <<< 1);
      end
      chev_pkg::OP_ACC: begin
        coef_d.c0 = chev_pkg::Q30 - (fa <<< 1);
        coef_d.c1 = (fa <<< 1) + fa - chev_pkg::Q31;
        coef_d.c2 = (fa <<< 1) + fa - chev_pkg::Q30;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    first_time_d = first_time_q;
    last_time_d  = last_time_q;
    t_d          = t_q;
    op_d         = op_q;
    single_d     = single_q;
    a_d          = a_q;
    scan_d       = scan_q;
    cmp_v_d      = cmp_v_q;
    cmp_idx_d    = cmp_idx_q;
    dt_d         = dt_q;
    frac_d       = frac_q;
    frac2_d      = frac2_q;
    frac3_d      = frac3_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    addr_a       = a_q;
    addr_b       = a_q + IDX_W'(1);
    mem_we       = 1'b0;
    frac_start   = 1'b0;
    lane_start   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          t_d     = in_item_i.at_time;
          res_d   = '0;
          state_d = S_OUT;
          case (in_item_i.req_type)
            chev_pkg::REQ_APPEND: begin
              if (cnt_q == MAX_CNT) begin
                res_d.status = chev_pkg::ST_FULL;
              end else if (cnt_q != '0 && in_item_i.at_time <= last_time_q) begin
                res_d.status = chev_pkg::ST_NOT_INC;
              end else begin
                mem_we      = 1'b1;
                cnt_d       = cnt_q + CNT_W'(1);
                last_time_d = in_item_i.at_time;
                if (cnt_q == '0) begin
                  first_time_d = in_item_i.at_time;
                end
              end
            end
            chev_pkg::REQ_CLEAR: begin
              cnt_d = '0;
            end
            chev_pkg::REQ_POS, chev_pkg::REQ_VEL, chev_pkg::REQ_ACC: begin
              if (in_item_i.req_type == chev_pkg::REQ_POS) begin
                op_d = chev_pkg::OP_POS;
              end else if (in_item_i.req_type == chev_pkg::REQ_VEL) begin
                op_d = chev_pkg::OP_VEL;
              end else begin
                op_d = chev_pkg::OP_ACC;
              end
              a_d = '0;
              if (cnt_q == '0) begin
                res_d.status = chev_pkg::ST_RANGE;
              end else if (cnt_q == CNT_W'(1)) begin
                // A lone knot answers only position or velocity at its own time.
                if (in_item_i.req_type == chev_pkg::REQ_ACC ||
                    in_item_i.at_time != first_time_q) begin
                  res_d.status = chev_pkg::ST_RANGE;
                end else begin
                  single_d = 1'b1;
                  state_d  = S_FETCH;
                end
              end else if (in_item_i.at_time < first_time_q ||
                           in_item_i.at_time > last_time_q) begin
                res_d.status = chev_pkg::ST_RANGE;
              end else begin
                single_d = 1'b0;
                scan_d   = IDX_W'(1);
                cmp_v_d  = 1'b0;
                state_d  = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // Reads of knots 1 to n-2 are pipelined with the compares on the registered read data.
        addr_a    = scan_q;
        cmp_v_d   = scan_issue;
        cmp_idx_d = scan_q;
        if (scan_issue) begin
          scan_d = scan_q + IDX_W'(1);
        end
        if (cmp_v_q && rd_a_q.at_time <= t_q) begin
          a_d = cmp_idx_q;
        end
        if (!scan_issue && !cmp_v_q) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_PAIR;
      end
      S_PAIR: begin
        if (single_q) begin
          res_d = '0;
          if (op_q == chev_pkg::OP_POS) begin
            res_d.res_x = rd_a_q.pos_x;
            res_d.res_y = rd_a_q.pos_y;
            res_d.res_z = rd_a_q.pos_z;
          end else begin
            res_d.res_x = rd_a_q.vel_x;
            res_d.res_y = rd_a_q.vel_y;
            res_d.res_z = rd_a_q.vel_z;
          end
          state_d = S_OUT;
        end else begin
          dt_d       = rd_b_q.at_time - rd_a_q.at_time;
          frac_start = 1'b1;
          state_d    = S_FRAC;
        end
      end
      S_FRAC: begin
        if (frac_done) begin
          frac_d  = frac_quot[30:0];
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        frac2_d = sq_prod[60:30];
        state_d = S_CUBE;
      end
      S_CUBE: begin
        frac3_d = sq_prod[60:30];
        state_d = S_COEF;
      end
      S_COEF: begin
        state_d = S_LSTART;
      end
      S_LSTART: begin
        lane_start = 1'b1;
        state_d    = S_LANES;
      end
      S_LANES: begin
        if (&lane_done) begin
          res_d       = '0;
          res_d.res_x = lane_res[0];
          res_d.res_y = lane_res[1];
          res_d.res_z = lane_res[2];
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cmp_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cmp_v_q     <= cmp_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_time_q <= first_time_d;
    last_time_q  <= last_time_d;
    t_q          <= t_d;
    op_q         <= op_d;
    single_q     <= single_d;
    a_q          <= a_d;
    scan_q       <= scan_d;
    cmp_idx_q    <= cmp_idx_d;
    dt_q         <= dt_d;
    frac_q       <= frac_d;
    frac2_q      <= frac2_d;
    frac3_q      <= frac3_d;
    coef_q       <= (state_q == S_COEF) ? coef_d : coef_q;
    res_q        <= res_d;
    out_q        <= out_d;
  end

  chev_div u_frac_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (frac_start),
    .dividend_i (frac_dividend),
    .divisor_i  (rd_b_q.at_time - rd_a_q.at_time),
    .done_o     (frac_done),
    .quot_o     (frac_quot)
  );

  assign lane_pa[0] = rd_a_q.pos_x;
  assign lane_pa[1] = rd_a_q.pos_y;
  assign lane_pa[2] = rd_a_q.pos_z;
  assign lane_pb[0] = rd_b_q.pos_x;
  assign lane_pb[1] = rd_b_q.pos_y;
  assign lane_pb[2] = rd_b_q.pos_z;
  assign lane_va[0] = rd_a_q.vel_x;
  assign lane_va[1] = rd_a_q.vel_y;
  assign lane_va[2] = rd_a_q.vel_z;
  assign lane_vb[0] = rd_b_q.vel_x;
  assign lane_vb[1] = rd_b_q.vel_y;
  assign lane_vb[2] = rd_b_q.vel_z;

  for (genvar l = 0; l < chev_pkg::NUM_LANES; l++) begin : g_lane
    chev_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (lane_start),
      .op_i    (op_q),
      .coef_i  (coef_q),
      .dt_i    (dt_q),
      .pa_i    (lane_pa[l]),
      .pb_i    (lane_pb[l]),
      .va_i    (lane_va[l]),
      .vb_i    (lane_vb[l]),
      .done_o  (lane_done[l]),
      .res_o   (lane_res[l])
    );
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[design/chev_checker.sv]
// Port-level checker of the cubic Hermite evaluator and its bind.
`default_nettype none

`include "cubic_hermite_3d_evaluator_unit_macros.svh"

module chev_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input chev_pkg::out_item_t out_item_o
);

  logic res_zero;

  assign res_zero = (out_item_o.res_x == '0) && (out_item_o.res_y == '0) &&
                    (out_item_o.res_z == '0);

  // A stalled result holds.
  `CHEV_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))

  // The block works on one item at a time.
  `CHEV_ASSERT(a_one_at_a_time, in_valid_i && in_ready_o |=> !in_ready_o)

  // Any error result carries zero coordinates.
  `CHEV_ASSERT(a_err_zero, out_valid_o && out_item_o.status != chev_pkg::ST_OK |-> res_zero)

  // No result is shown once reset has been seen at a clock edge.
  `CHEV_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o)

endmodule

bind cubic_hermite_3d_evaluator_unit chev_checker u_chev_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
